// ===== sv/imd_pkg.sv =====
`timescale 1ns / 1ps

package imd_pkg;

    // Image geometry default
    localparam int DEFAULT_IMAGE_SIDE = 256;

    // Field widths
    localparam int COORD_W   = 8;
    localparam int WEIGHT_W  = 16;
    localparam int VARIATE_W = 20;
    localparam int OP_W      = 2;

    // Sum of 8 coupling terms and one data term, Q.12, signed
    localparam int FIELD_W  = 20;
    localparam int ENERGY_W = FIELD_W + 1;

    // Wide enough for neighbor row/column arithmetic up to a side of 1024
    localparam int NB_W = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA     = 1'b1;
    localparam logic signed [WEIGHT_W-1:0] COUPLING_RESET = 16'sd4096;
    localparam logic signed [WEIGHT_W-1:0] DATA_RESET     = 16'sd4096;

    // Neighbor offsets: 0 means -1, 1 means 0, 2 means +1
    localparam logic [1:0] OFF_LOW  = 2'd0;
    localparam logic [1:0] OFF_MID  = 2'd1;
    localparam logic [1:0] OFF_HIGH = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [COORD_W-1:0]   pixel_row;
        logic [COORD_W-1:0]   pixel_col;
        logic                 pixel_value;
        logic [VARIATE_W-1:0] neg_log_uniform;
    } in_item_t;

    typedef struct packed {
        logic spin_value;
        logic flipped;
    } out_item_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic rd_en;
        logic fire;
        logic item_ok;
    } seq_stat_t;

    // Tags that travel with a memory read into the energy unit
    typedef struct packed {
        logic clear;
        logic neighbor;
        logic center;
    } acc_ctl_t;

    // Image store access
    typedef struct packed {
        logic rd_en;
        logic noisy_we;
        logic spin_we;
        logic wdata;
    } mem_ctl_t;

endpackage

// ===== sv/imd_in_if.sv =====
`timescale 1ns / 1ps

interface imd_in_if import imd_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== sv/imd_out_if.sv =====
`timescale 1ns / 1ps

interface imd_out_if import imd_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== sv/ising_metropolis_denoise_update_unit.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                                               Accepted when
// -------  ---  ----------------------------------------------------  ------------------
// req      in   operation, pixel_row, pixel_col, pixel_value,          req.valid & req.ready
//               neg_log_uniform
// rsp      out  spin_value, flipped                                   rsp.valid & rsp.ready
// cfg      in   cfg_we, cfg_index, cfg_data (plain write)             cfg_we
//
// Steps: load, unused code or out-of-image address: dispatch, then decide; read
// and update: dispatch, a 3x3 window scan through the single read port of the
// image store (one pixel per cycle), drain, decide.
// Reset: rst_n clears the sequencer, the output valid and the weights (1.0 each);
// image contents are undefined until loaded.
// Stalls: a finished item waits in the output register; the next item is taken
// meanwhile and only its final decide step waits for the output to free up.

module ising_metropolis_denoise_update_unit import imd_pkg::*; #(
    parameter int IMAGE_SIDE = DEFAULT_IMAGE_SIDE,
    localparam int ADDR_W = $clog2(IMAGE_SIDE * IMAGE_SIDE)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    imd_in_if.sink                req,
    imd_out_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    logic signed [WEIGHT_W-1:0] coupling_reg;
    logic signed [WEIGHT_W-1:0] data_reg;

    // Captured item
    op_t                  op_reg;
    logic [COORD_W-1:0]   row_reg;
    logic [COORD_W-1:0]   col_reg;
    logic                 pv_reg;
    logic [VARIATE_W-1:0] variate_reg;

    // Output register
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic              accept;
    logic              out_free;
    seq_stat_t         stat;
    acc_ctl_t          acc_ctl;
    mem_ctl_t          mem_ctl;
    logic [ADDR_W-1:0] addr;
    logic              noisy_q;
    logic              spin_q;
    logic              spin_z;
    logic              flip;
    logic              do_flip;
    out_item_t         result;

    assign req.ready = stat.idle;
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Weights: write only while idle, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg <= COUPLING_RESET;
            data_reg     <= DATA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COUPLING: coupling_reg <= cfg_data;
                REG_DATA:     data_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Hold the accepted item for the whole operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_t'(req.item.operation);
            row_reg     <= req.item.pixel_row;
            col_reg     <= req.item.pixel_col;
            pv_reg      <= req.item.pixel_value;
            variate_reg <= req.item.neg_log_uniform;
        end
    end

    imd_sequencer #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .op       (op_reg),
        .row      (row_reg),
        .col      (col_reg),
        .out_free (out_free),
        .stat     (stat),
        .acc_ctl  (acc_ctl),
        .addr     (addr)
    );

    imd_energy_unit u_energy (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (acc_ctl),
        .noisy_q         (noisy_q),
        .spin_q          (spin_q),
        .coupling_weight (coupling_reg),
        .data_weight     (data_reg),
        .neg_log_uniform (variate_reg),
        .spin_z          (spin_z),
        .flip            (flip)
    );

    // Decide: a load writes both images, an update writes back the flipped spin
    always_comb
    begin
        do_flip = stat.item_ok && (op_reg == OP_UPDATE) && flip;

        mem_ctl          = '0;
        mem_ctl.rd_en    = stat.rd_en;
        mem_ctl.wdata    = (op_reg == OP_LOAD) ? pv_reg : !spin_z;
        mem_ctl.noisy_we = stat.fire && stat.item_ok && (op_reg == OP_LOAD);
        mem_ctl.spin_we  = stat.fire && (mem_ctl.noisy_we || do_flip);

        result = '0;
        if (stat.item_ok)
        begin
            case (op_reg)
                OP_LOAD:
                begin
                    result.spin_value = pv_reg;
                end
                OP_UPDATE:
                begin
                    result.spin_value = spin_z ^ do_flip;
                    result.flipped    = do_flip;
                end
                OP_READ:
                begin
                    result.spin_value = spin_z;
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    imd_image_store #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (addr),
        .noisy_q (noisy_q),
        .spin_q  (spin_q)
    );

    // Output register: load on fire, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (stat.fire)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    // An accepted item closes the input until it is done
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("input taken while an item is in progress");

    // Image writes happen only at the decide step of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.spin_we || mem_ctl.noisy_we) |-> stat.fire)
        else $error("image write outside the decide step");

    // A finished item always shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.fire |=> rsp.valid)
        else $error("finished item not presented");

endmodule

// ===== sv/imd_image_store.sv =====
`timescale 1ns / 1ps

module imd_image_store import imd_pkg::*; #(
    parameter int IMAGE_SIDE = DEFAULT_IMAGE_SIDE,
    localparam int DEPTH  = IMAGE_SIDE * IMAGE_SIDE,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [ADDR_W-1:0] addr,
    output logic              noisy_q,
    output logic              spin_q
);

    logic noisy_mem [DEPTH];
    logic spin_mem  [DEPTH];

    // One address per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (ctl.noisy_we)
        begin
            noisy_mem[addr] <= ctl.wdata;
        end
        if (ctl.spin_we)
        begin
            spin_mem[addr] <= ctl.wdata;
        end
        if (ctl.rd_en)
        begin
            noisy_q <= noisy_mem[addr];
            spin_q  <= spin_mem[addr];
        end
    end

endmodule

// ===== sv/imd_energy_unit.sv =====
`timescale 1ns / 1ps

module imd_energy_unit import imd_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  acc_ctl_t                   ctl,
    input  logic                       noisy_q,
    input  logic                       spin_q,
    input  logic signed [WEIGHT_W-1:0] coupling_weight,
    input  logic signed [WEIGHT_W-1:0] data_weight,
    input  logic [VARIATE_W-1:0]       neg_log_uniform,
    output logic                       spin_z,
    output logic                       flip
);

    logic                       neighbor_reg;
    logic                       center_reg;
    logic signed [FIELD_W-1:0]  field_reg;
    logic signed [FIELD_W-1:0]  field_next;
    logic                       z_reg;
    logic signed [FIELD_W-1:0]  weight_ext;
    logic signed [FIELD_W-1:0]  addend;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [ENERGY_W:0]   energy_ext;
    logic signed [ENERGY_W:0]   variate_ext;

    // Tags line up with the registered memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neighbor_reg <= 1'b0;
            center_reg   <= 1'b0;
        end
        else
        begin
            neighbor_reg <= ctl.neighbor;
            center_reg   <= ctl.center;
        end
    end

    // Shared adder: one signed weight per cycle, sign set by the stored bit
    always_comb
    begin
        if (center_reg)
        begin
            weight_ext = FIELD_W'(data_weight);
            addend     = noisy_q ? weight_ext : -weight_ext;
        end
        else
        begin
            weight_ext = FIELD_W'(coupling_weight);
            addend     = spin_q ? weight_ext : -weight_ext;
        end

        if (ctl.clear)
        begin
            field_next = '0;
        end
        else if (neighbor_reg || center_reg)
        begin
            field_next = field_reg + addend;
        end
        else
        begin
            field_next = field_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        field_reg <= field_next;
        if (center_reg)
        begin
            z_reg <= spin_q;
        end
    end

    // energy = 2*z*field, flip when below the variate
    always_comb
    begin
        energy      = z_reg ? {field_reg, 1'b0} : -{field_reg, 1'b0};
        energy_ext  = {energy[ENERGY_W-1], energy};
        variate_ext = {2'b00, neg_log_uniform};
    end

    assign flip   = energy_ext < variate_ext;
    assign spin_z = z_reg;

endmodule

// ===== sv/imd_sequencer.sv =====
`timescale 1ns / 1ps

module imd_sequencer import imd_pkg::*; #(
    parameter int IMAGE_SIDE = DEFAULT_IMAGE_SIDE,
    localparam int ADDR_W = $clog2(IMAGE_SIDE * IMAGE_SIDE)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  op_t                op,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] col,
    input  logic               out_free,
    output seq_stat_t          stat,
    output acc_ctl_t           acc_ctl,
    output logic [ADDR_W-1:0]  addr
);

    localparam logic [NB_W-1:0] SIDE = NB_W'(IMAGE_SIDE);
    localparam logic [NB_W-1:0] ONE  = NB_W'(1);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] roff_reg;
    logic [1:0] roff_next;
    logic [1:0] coff_reg;
    logic [1:0] coff_next;
    logic       ok_reg;
    logic       ok_next;

    logic            item_ok;
    logic            last_pos;
    logic [1:0]      off_r;
    logic [1:0]      off_c;
    logic [NB_W-1:0] row_w;
    logic [NB_W-1:0] col_w;
    logic [NB_W-1:0] nb_row;
    logic [NB_W-1:0] nb_col;
    logic            row_in;
    logic            col_in;
    logic            at_center;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            roff_reg  <= OFF_LOW;
            coff_reg  <= OFF_LOW;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            roff_reg  <= roff_next;
            coff_reg  <= coff_next;
            ok_reg    <= ok_next;
        end
    end

    assign row_w    = NB_W'(row);
    assign col_w    = NB_W'(col);
    assign item_ok  = (row_w < SIDE) && (col_w < SIDE) && (op != OP_NONE);
    assign last_pos = (roff_reg == OFF_HIGH) && (coff_reg == OFF_HIGH);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!item_ok || op == OP_LOAD)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window position and item check
    always_comb
    begin
        roff_next = roff_reg;
        coff_next = coff_reg;
        ok_next   = ok_reg;
        if (state_reg == ST_DISPATCH)
        begin
            roff_next = OFF_LOW;
            coff_next = OFF_LOW;
            ok_next   = item_ok;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (coff_reg == OFF_HIGH)
            begin
                coff_next = OFF_LOW;
                roff_next = roff_reg + 2'd1;
            end
            else
            begin
                coff_next = coff_reg + 2'd1;
            end
        end
    end

    // Neighbor address and range
    always_comb
    begin
        off_r  = (state_reg == ST_SCAN) ? roff_reg : OFF_MID;
        off_c  = (state_reg == ST_SCAN) ? coff_reg : OFF_MID;
        nb_row = row_w + NB_W'(off_r) - ONE;
        nb_col = col_w + NB_W'(off_c) - ONE;

        case (off_r)
            OFF_LOW:  row_in = (row_w != '0);
            OFF_HIGH: row_in = (row_w + ONE) < SIDE;
            default:  row_in = 1'b1;
        endcase
        case (off_c)
            OFF_LOW:  col_in = (col_w != '0);
            OFF_HIGH: col_in = (col_w + ONE) < SIDE;
            default:  col_in = 1'b1;
        endcase

        at_center = (off_r == OFF_MID) && (off_c == OFF_MID);
    end

    assign addr = ADDR_W'(nb_row) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(nb_col);

    // Outputs
    always_comb
    begin
        stat             = '0;
        acc_ctl          = '0;
        stat.item_ok     = ok_reg;
        stat.idle        = (state_reg == ST_IDLE);
        stat.fire        = (state_reg == ST_DECIDE) && out_free;
        acc_ctl.clear    = (state_reg == ST_DISPATCH);
        if (state_reg == ST_SCAN)
        begin
            stat.rd_en       = row_in && col_in;
            acc_ctl.neighbor = row_in && col_in && !at_center;
            acc_ctl.center   = at_center;
        end
    end

endmodule
